### hw/rtl/etot_pkg.sv
package etot_pkg;

    localparam int WIDTH_DEFAULT = 32;
    localparam int N_W = 32;
    localparam int PHI_W = 32;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

### hw/rtl/etot_div.sv
module etot_div #(
    parameter int WIDTH = etot_pkg::WIDTH_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [WIDTH-1:0]       i_dividend,
    input  logic [WIDTH-1:0]       i_divisor,
    output logic [WIDTH-1:0]       o_quo,
    output logic [WIDTH-1:0]       o_rem,
    output etot_pkg::t_unit_stat   o_stat
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_dsr;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic [WIDTH-1:0] n_rem;
    logic             q_bit;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        shifted = {r_rem, r_quo[WIDTH-1]};
        diff    = shifted - {1'b0, r_dsr};
        q_bit   = ~diff[WIDTH];
        n_rem   = q_bit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(WIDTH);
                r_quo <= i_dividend;
                r_rem <= '0;
                r_dsr <= i_divisor;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_quo <= {r_quo[WIDTH-2:0], q_bit};
                r_rem <= n_rem;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo       = r_quo;
    assign o_rem       = r_rem;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

endmodule

### hw/rtl/etot_mul.sv
module etot_mul #(
    parameter int WIDTH = etot_pkg::WIDTH_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [WIDTH-1:0]       i_a,
    input  logic [WIDTH-1:0]       i_b,
    output logic [WIDTH-1:0]       o_prod,
    output etot_pkg::t_unit_stat   o_stat
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_acc;

    // Shift and add, one multiplier bit per cycle; only the low word is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(WIDTH);
                r_a   <= i_a;
                r_b   <= i_b;
                r_acc <= '0;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_a   <= {r_a[WIDTH-2:0], 1'b0};
                r_b   <= {1'b0, r_b[WIDTH-1:1]};
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod      = r_acc;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

endmodule

### hw/rtl/euler_totient.sv
// Channel | Direction | Handshake          | Payload
// input   | in        | i_valid / o_stall  | i_n
// output  | out       | o_valid / i_stall  | o_phi_value, o_invalid
//
// One transaction is worked at a time; o_stall is high from acceptance until the
// result is loaded. Each trial divisor costs one pass of the serial divider;
// stripping a prime costs one such pass per power found plus one,
// and scaling costs one divider pass and one multiplier pass.
// A WIDTH-bit prime n needs about sqrt(n) divider passes.
// Zero in skips the divider and goes straight to S_DONE; the synchronous reset clears all control state.
// A result waiting on i_stall holds its register; the next transaction is still taken meanwhile.
module euler_totient #(
    parameter int WIDTH = etot_pkg::WIDTH_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [etot_pkg::N_W-1:0]  i_n,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [etot_pkg::PHI_W-1:0] o_phi_value,
    output logic                      o_invalid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_FIND,
        S_STRIP,
        S_SCALE,
        S_MUL,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [WIDTH-1:0] r_result;
    logic [WIDTH-1:0] r_rest;
    logic [WIDTH-1:0] r_d;
    logic [WIDTH-1:0] r_p;
    logic             r_inv;
    logic             r_div_start;
    logic [WIDTH-1:0] r_div_a;
    logic [WIDTH-1:0] r_div_b;
    logic             r_mul_start;
    logic [WIDTH-1:0] r_mul_a;
    logic [WIDTH-1:0] r_mul_b;
    logic             r_o_valid;
    logic [etot_pkg::PHI_W-1:0] r_o_phi;
    logic             r_o_inv;

    logic [WIDTH-1:0]     div_quo;
    logic [WIDTH-1:0]     div_rem;
    logic [WIDTH-1:0]     mul_prod;
    logic [WIDTH-1:0]     n_in;
    logic [WIDTH-1:0]     n_d;
    etot_pkg::t_unit_stat div_stat;
    etot_pkg::t_unit_stat mul_stat;

    etot_div #(.WIDTH(WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_quo      (div_quo),
        .o_rem      (div_rem),
        .o_stat     (div_stat)
    );

    etot_mul #(.WIDTH(WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_prod  (mul_prod),
        .o_stat  (mul_stat)
    );

    assign n_in = WIDTH'(i_n);
    assign n_d  = r_d + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            if (r_o_valid && !i_stall && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_result <= n_in;
                        r_rest   <= n_in;
                        r_d      <= WIDTH'(2);
                        if (n_in == '0) begin
                            r_inv   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_inv   <= 1'b0;
                            r_state <= S_TEST;
                        end
                    end
                end
                S_TEST: begin
                    if (r_rest <= WIDTH'(1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_div_a     <= r_rest;
                        r_div_b     <= r_d;
                        r_div_start <= 1'b1;
                        r_state     <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (div_stat.done) begin
                        r_div_a     <= r_rest;
                        r_div_start <= 1'b1;
                        if (div_rem == '0) begin
                            r_p     <= r_d;
                            r_div_b <= r_d;
                            r_state <= S_STRIP;
                        end else if (r_d > div_quo) begin
                            r_p     <= r_rest;
                            r_div_b <= r_rest;
                            r_state <= S_STRIP;
                        end else begin
                            r_d     <= n_d;
                            r_div_b <= n_d;
                        end
                    end
                end
                S_STRIP: begin
                    if (div_stat.done) begin
                        r_div_b     <= r_p;
                        r_div_start <= 1'b1;
                        if (div_rem == '0) begin
                            r_rest  <= div_quo;
                            r_div_a <= div_quo;
                        end else begin
                            r_div_a <= r_result;
                            r_state <= S_SCALE;
                        end
                    end
                end
                S_SCALE: begin
                    if (div_stat.done) begin
                        r_mul_a     <= div_quo;
                        r_mul_b     <= r_p - 1'b1;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mul_stat.done) begin
                        r_result <= mul_prod;
                        r_state  <= S_TEST;
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_phi   <= r_inv ? '0 : etot_pkg::PHI_W'(r_result);
                        r_o_inv   <= r_inv;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_phi_value = r_o_phi;
    assign o_invalid   = r_o_inv;

`ifndef SYNTHESIS
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_stat.busy && mul_stat.busy))
        else $error("divider and multiplier busy together");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_phi_value == '0))
        else $error("invalid result carries a nonzero totient");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("accepted transaction did not occupy the datapath");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [etot_pkg::N_W-1:0]   n;
        logic [etot_pkg::PHI_W-1:0] phi_value;
        logic                       invalid;
    } t_totient;

    class t_totient_board;
        t_totient waiting[$];
        int       mismatches;
        int       results_seen;

        function new();
            mismatches = 0;
            results_seen = 0;
        endfunction

        // Trial division in 64-bit arithmetic, so the square test cannot wrap.
        function logic [etot_pkg::PHI_W-1:0] totient_of(logic [etot_pkg::N_W-1:0] n);
            bit [63:0] acc;
            bit [63:0] rest;
            bit [63:0] div;
            bit [63:0] prime;
            acc = 64'(n);
            rest = 64'(n);
            div = 64'd2;
            while (rest > 64'd1) begin
                prime = '0;
                while (prime == '0) begin
                    if (rest % div == '0) begin
                        prime = div;
                    end else if (div > rest / div) begin
                        prime = rest;
                    end else begin
                        div++;
                    end
                end
                while (rest % prime == '0) begin
                    rest = rest / prime;
                end
                acc = (acc / prime) * (prime - 64'd1);
            end
            return acc[etot_pkg::PHI_W-1:0];
        endfunction

        function void note_input(logic [etot_pkg::N_W-1:0] n);
            t_totient want;
            want.n = n;
            want.invalid = (n == '0);
            want.phi_value = (n == '0) ? '0 : totient_of(n);
            waiting.push_back(want);
        endfunction

        function void check_result(logic [etot_pkg::PHI_W-1:0] phi_value, logic invalid);
            t_totient want;
            results_seen++;
            if (waiting.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: phi %0d invalid %0b arrived with nothing pending",
                             results_seen, phi_value, invalid);
                end
            end else begin
                want = waiting.pop_front();
                if (phi_value !== want.phi_value || invalid !== want.invalid) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d (n=%0d): got %0d/%0b, expected %0d/%0b",
                                 results_seen, want.n, phi_value, invalid,
                                 want.phi_value, want.invalid);
                    end
                end
            end
        endfunction

        function int outstanding();
            return waiting.size();
        endfunction

        function bit all_good();
            return (mismatches == 0) && (waiting.size() == 0);
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [etot_pkg::N_W-1:0]   i_n = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [etot_pkg::PHI_W-1:0] o_phi_value;
    logic                       o_invalid;

    t_totient_board board = new();
    bit             tx_idle_on = 1'b1;
    bit             rx_idle_on = 1'b1;
    int             stall_left = 0;
    int             cycle_count = 0;

    euler_totient uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_n         (i_n),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_phi_value (o_phi_value),
        .o_invalid   (o_invalid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("euler_totient: mismatch");
            $finish;
        end
    end

    // After each result taken, the receiver may stall if rx_idle_on is set.
    always @(posedge i_clk) begin
        int hold;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && !i_stall) begin
            board.check_result(o_phi_value, o_invalid);
            hold = rx_idle_on ? int'($urandom_range(0, 3)) : 0;
            stall_left <= hold;
            if (hold > 0) begin
                i_stall <= 1'b1;
            end
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_n(logic [etot_pkg::N_W-1:0] value);
        int gap;
        gap = tx_idle_on ? int'($urandom_range(0, 3)) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_n <= value;
        do @(posedge i_clk); while (o_stall);
        board.note_input(value);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.outstanding() > 0) @(posedge i_clk);
    endtask

    function automatic logic [etot_pkg::N_W-1:0] smooth_value();
        bit [63:0] acc;
        bit [63:0] factor;
        int steps;
        acc = 64'd1;
        steps = $urandom_range(1, 30);
        repeat (steps) begin
            factor = 64'($urandom_range(2, 251));
            if (acc * factor <= 64'hFFFF_FFFF) begin
                acc = acc * factor;
            end
        end
        return acc[etot_pkg::N_W-1:0];
    endfunction

    function automatic logic [etot_pkg::N_W-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 2))
                0: return '0;
                1: return 32'd1;
                default: return 32'd1 << $urandom_range(0, 31);
            endcase
        end else if (pick <= 2) begin
            return $urandom_range(0, 65535);
        end else if (pick <= 4) begin
            return $urandom_range(0, 4095);
        end
        return smooth_value();
    endfunction

    logic [etot_pkg::N_W-1:0] directed[] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd0, 32'd0,
        32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
        32'hFFFF_0000, 32'd4294836225, 32'd3486784401,
        32'd9, 32'd25, 32'd49, 32'd221, 32'd4095,
        32'd65536, 32'd65537, 32'd65521, 32'd720720, 32'd1000000,
        32'd16777213
    };

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_n(directed[k]);
        end
        wait_drained();

        for (int k = 0; k < 100; k++) begin
            if (k % 25 == 0) begin
                tx_idle_on = (k % 50 == 0);
                rx_idle_on = (k % 75 != 0);
            end
            if (k == 50) begin
                wait_drained();
            end
            send_n(random_value());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.all_good()) begin
            $display("euler_totient: match");
        end else begin
            $display("euler_totient: mismatch");
        end
        $finish;
    end

endmodule

### euler_totient.f
hw/rtl/etot_pkg.sv
hw/rtl/etot_div.sv
hw/rtl/etot_mul.sv
hw/rtl/euler_totient.sv
tb/testbench.sv
